### design/hryc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and tables of the hover rudder yaw control law.
package hryc_pkg;

  localparam int CfgDataW = 16;

  localparam logic [15:0]        PropGainRst  = 16'd4096;
  localparam logic [15:0]        DerivGainRst = 16'd4096;
  localparam logic signed [15:0] OverrideRst  = 16'sd0;
  localparam logic signed [15:0] TrimRst      = 16'sd0;

  localparam int PiQ16     = 205887;
  localparam int HalfPiQ16 = 102944;
  localparam int PiQ13     = 25736;
  localparam int K064Q16   = 41943;
  localparam int K02Q29    = 107374182;
  localparam int K03Q16    = 19661;
  localparam int K06Q16    = 39322;
  localparam int CosOne    = 16384;
  localparam int WOne      = 65536;

  localparam int CordicSteps = 16;
  localparam int AtanQ16 [CordicSteps] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  typedef enum logic [1:0] {
    CFG_PROP_GAIN  = 2'd0,
    CFG_DERIV_GAIN = 2'd1,
    CFG_OVERRIDE   = 2'd2,
    CFG_YAW_TRIM   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] rot_xz;
    logic signed [15:0] rot_yz;
    logic signed [15:0] rot_zz;
    logic signed [15:0] rot_xy;
    logic signed [15:0] rot_yy;
    logic signed [15:0] rot_zy;
    logic signed [15:0] yaw_rate;
    logic signed [15:0] yaw_rate_mean;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] rudder_command;
    logic               command_clipped;
  } out_item_t;

endpackage

### design/hryc_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, with side data.
module hryc_sqrt
  import hryc_pkg::*;
#(
  parameter int RootW = 23,
  parameter int SideW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [2*RootW-1:0] in_rad,
  input  logic [SideW-1:0]   in_side,
  output logic               out_valid,
  output logic [RootW-1:0]   out_root,
  output logic [SideW-1:0]   out_side
);

  logic               v_r    [RootW];
  logic [2*RootW-1:0] rad_r  [RootW];
  logic [RootW+1:0]   rem_r  [RootW];
  logic [RootW-1:0]   root_r [RootW];
  logic [SideW-1:0]   side_r [RootW];

  for (genvar j = 0; j < RootW; j++) begin : g_stage
    logic               pv;
    logic [2*RootW-1:0] prad;
    logic [RootW+1:0]   prem;
    logic [RootW-1:0]   proot;
    logic [SideW-1:0]   pside;
    logic [RootW+1:0]   pre;
    logic [RootW+1:0]   trial;
    logic               ge;

    if (j == 0) begin : g_first
      assign pv    = in_valid;
      assign prad  = in_rad;
      assign prem  = '0;
      assign proot = '0;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = v_r[j-1];
      assign prad  = rad_r[j-1];
      assign prem  = rem_r[j-1];
      assign proot = root_r[j-1];
      assign pside = side_r[j-1];
    end

    assign pre   = {prem[RootW-1:0], prad[2*RootW-1 -: 2]};
    assign trial = {proot, 2'b01};
    assign ge    = (pre >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[j]  <= prad << 2;
        rem_r[j]  <= ge ? (pre - trial) : pre;
        root_r[j] <= {proot[RootW-2:0], ge};
        side_r[j] <= pside;
      end
    end
  end

  assign out_valid = v_r[RootW-1];
  assign out_root  = root_r[RootW-1];
  assign out_side  = side_r[RootW-1];

endmodule

### design/hover_rudder_yaw_control_law.sv
`timescale 1ns / 1ps
// Top level of the hover rudder yaw control law.
//
// One attitude sample goes in on the in_ channel and one rudder command comes
// out on the out_ channel. Both channels use valid and stall; an item moves at
// a clock edge where valid is high and stall is low.
// The datapath is a pipeline of 83 register stages, and one item can be accepted
// in every cycle while out_stall does not hold the pipeline.
// The depth is set by the two square roots (one root bit per stage), the
// restoring divider for the cosine (one quotient bit per stage) and the
// sixteen CORDIC steps of the arc cosine.
// When out_stall is high while a result waits, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
// The cfg_ port writes the gains, the override command and the heading trim;
// write it only while no item is in flight.
// A synchronous reset empties the pipeline and loads the default register
// values: both gains one, override and trim zero.
module hover_rudder_yaw_control_law
  import hryc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_item,
  input  logic                cfg_we,
  input  cfg_idx_t            cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int Sq1W   = 23;
  localparam int Sq2W   = 15;
  localparam int QuotW  = 15;
  localparam int CordW  = 28;
  localparam int AngW   = 20;

  typedef struct packed {
    logic signed [32:0] n;
    logic signed [16:0] dz;
    logic               pos;
    logic               neg;
    logic               mz;
  } sq1_side_t;

  typedef struct packed {
    logic signed [16:0] dz;
    logic               pos;
    logic               neg;
    logic               mz;
    logic               sat;
    logic               nneg;
    logic [Sq1W-1:0]    f21;
  } div_side_t;

  typedef struct packed {
    logic signed [15:0] c;
    logic signed [16:0] dz;
    logic               pos;
    logic               neg;
    logic               mz;
    logic [15:0]        factor;
  } sq2_side_t;

  typedef struct packed {
    logic signed [16:0] dz;
    logic               pos;
    logic               neg;
    logic               mz;
    logic [15:0]        factor;
  } cord_side_t;

  // Configuration registers.
  logic [15:0]        prop_gain_r;
  logic [15:0]        deriv_gain_r;
  logic signed [15:0] override_r;
  logic signed [15:0] trim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= PropGainRst;
      deriv_gain_r <= DerivGainRst;
      override_r   <= OverrideRst;
      trim_r       <= TrimRst;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROP_GAIN:  prop_gain_r  <= cfg_data;
        CFG_DERIV_GAIN: deriv_gain_r <= cfg_data;
        CFG_OVERRIDE:   override_r   <= $signed(cfg_data);
        CFG_YAW_TRIM:   trim_r       <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  logic adv;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Stage 1: squares and cross products of the axes.
  logic signed [31:0] p_zzzz, p_zyzy, p_zzyy, p_zyyz, p_zyyy, p_zzyz;
  logic [31:0]        s1_m_nxt;
  logic signed [32:0] s1_n_nxt, s1_t_nxt;
  logic signed [16:0] s1_dz_nxt;

  assign p_zzzz    = in_item.rot_zz * in_item.rot_zz;
  assign p_zyzy    = in_item.rot_yz * in_item.rot_yz;
  assign p_zzyy    = in_item.rot_zz * in_item.rot_yy;
  assign p_zyyz    = in_item.rot_yz * in_item.rot_zy;
  assign p_zyyy    = in_item.rot_yz * in_item.rot_yy;
  assign p_zzyz    = in_item.rot_zz * in_item.rot_zy;
  assign s1_m_nxt  = $unsigned(p_zzzz) + $unsigned(p_zyzy);
  assign s1_n_nxt  = 33'(p_zzyy) - 33'(p_zyyz);
  assign s1_t_nxt  = 33'(p_zyyy) + 33'(p_zzyz);
  assign s1_dz_nxt = 17'(in_item.yaw_rate) - 17'(in_item.yaw_rate_mean);

  logic               s1_v_r;
  logic [31:0]        s1_m_r;
  logic signed [32:0] s1_n_r, s1_t_r;
  logic signed [16:0] s1_dz_r;
  logic signed [15:0] s1_zx_r, s1_yx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_m_r  <= s1_m_nxt;
      s1_n_r  <= s1_n_nxt;
      s1_t_r  <= s1_t_nxt;
      s1_dz_r <= s1_dz_nxt;
      s1_zx_r <= in_item.rot_xz;
      s1_yx_r <= in_item.rot_xy;
    end
  end

  // Stage 2: the two terms of the sign product.
  logic signed [48:0] s2_pa_nxt, s2_pb_nxt;

  assign s2_pa_nxt = 49'($signed({1'b0, s1_m_r})) * 49'(s1_yx_r);
  assign s2_pb_nxt = 49'(s1_zx_r) * 49'(s1_t_r);

  logic               s2_v_r;
  logic signed [48:0] s2_pa_r, s2_pb_r;
  logic [31:0]        s2_m_r;
  logic signed [32:0] s2_n_r;
  logic signed [16:0] s2_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pa_r <= s2_pa_nxt;
      s2_pb_r <= s2_pb_nxt;
      s2_m_r  <= s1_m_r;
      s2_n_r  <= s1_n_r;
      s2_dz_r <= s1_dz_r;
    end
  end

  // Stage 3: sign of the heading error and the root's radicand.
  logic signed [49:0] sgn;
  sq1_side_t          s3_side_nxt;

  assign sgn               = 50'(s2_pb_r) - 50'(s2_pa_r);
  assign s3_side_nxt.n     = s2_n_r;
  assign s3_side_nxt.dz    = s2_dz_r;
  assign s3_side_nxt.pos   = !sgn[49] && (sgn != '0);
  assign s3_side_nxt.neg   = sgn[49];
  assign s3_side_nxt.mz    = (s2_m_r == '0);

  logic              s3_v_r;
  logic [2*Sq1W-1:0] s3_rad_r;
  sq1_side_t         s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_rad_r  <= {s2_m_r, 14'b0};
      s3_side_r <= s3_side_nxt;
    end
  end

  logic            sq1_v;
  logic [Sq1W-1:0] sq1_root;
  sq1_side_t       sq1_side;

  hryc_sqrt #(
    .RootW (Sq1W),
    .SideW ($bits(sq1_side_t))
  ) u_sqrt_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s3_v_r),
    .in_rad    (s3_rad_r),
    .in_side   (s3_side_r),
    .out_valid (sq1_v),
    .out_root  (sq1_root),
    .out_side  (sq1_side)
  );

  // Divider setup: magnitude of the scaled numerator and overflow check.
  logic signed [32:0] n_abs;
  logic [39:0]        d0_mag_nxt;
  div_side_t          d0_side_nxt;

  assign n_abs           = sq1_side.n[32] ? -sq1_side.n : sq1_side.n;
  assign d0_mag_nxt      = 40'({n_abs[31:0], 7'b0});
  assign d0_side_nxt.dz  = sq1_side.dz;
  assign d0_side_nxt.pos = sq1_side.pos;
  assign d0_side_nxt.neg = sq1_side.neg;
  assign d0_side_nxt.mz  = sq1_side.mz;
  assign d0_side_nxt.sat = (d0_mag_nxt >= 40'({sq1_root, 15'b0}));
  assign d0_side_nxt.nneg = sq1_side.n[32];
  assign d0_side_nxt.f21 = sq1_root;

  logic        d0_v_r;
  logic [39:0] d0_mag_r;
  div_side_t   d0_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0_v_r <= 1'b0;
    end else if (adv) begin
      d0_v_r <= sq1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d0_mag_r  <= d0_mag_nxt;
      d0_side_r <= d0_side_nxt;
    end
  end

  // Restoring divider, one quotient bit per stage from the top.
  logic             dv_v_r    [QuotW];
  logic [39:0]      dv_rem_r  [QuotW];
  logic [QuotW-1:0] dv_q_r    [QuotW];
  div_side_t        dv_side_r [QuotW];

  for (genvar i = 0; i < QuotW; i++) begin : g_div
    localparam int Sh = QuotW - 1 - i;
    logic             pv;
    logic [39:0]      prem;
    logic [QuotW-1:0] pq;
    div_side_t        pside;
    logic [39:0]      dvs;
    logic             ge;

    if (i == 0) begin : g_first
      assign pv    = d0_v_r;
      assign prem  = d0_mag_r;
      assign pq    = '0;
      assign pside = d0_side_r;
    end else begin : g_next
      assign pv    = dv_v_r[i-1];
      assign prem  = dv_rem_r[i-1];
      assign pq    = dv_q_r[i-1];
      assign pside = dv_side_r[i-1];
    end

    assign dvs = 40'(pside.f21) << Sh;
    assign ge  = (prem >= dvs);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[i] <= 1'b0;
      end else if (adv) begin
        dv_v_r[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[i]  <= ge ? (prem - dvs) : prem;
        dv_q_r[i]    <= pq | (QuotW'(ge) << Sh);
        dv_side_r[i] <= pside;
      end
    end
  end

  // Cosine clamp and sign.
  div_side_t          dq_side;
  logic [QuotW-1:0]   dq_q;
  logic [QuotW-1:0]   c_mag;
  logic signed [15:0] c_nxt;

  assign dq_side = dv_side_r[QuotW-1];
  assign dq_q    = dv_q_r[QuotW-1];
  assign c_mag   = (dq_side.sat || (dq_q > QuotW'(CosOne))) ? QuotW'(CosOne) : dq_q;
  assign c_nxt   = dq_side.nneg ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});

  logic               cs_v_r;
  logic signed [15:0] cs_c_r;
  sq2_side_t          cs_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_v_r <= 1'b0;
    end else if (adv) begin
      cs_v_r <= dv_v_r[QuotW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs_c_r           <= c_nxt;
      cs_side_r.c      <= c_nxt;
      cs_side_r.dz     <= dq_side.dz;
      cs_side_r.pos    <= dq_side.pos;
      cs_side_r.neg    <= dq_side.neg;
      cs_side_r.mz     <= dq_side.mz;
      cs_side_r.factor <= 16'(dq_side.f21 >> 7);
    end
  end

  // Sine radicand 1 - c^2.
  logic signed [31:0] c_sq;
  logic              rs_v_r;
  logic [2*Sq2W-1:0] rs_rad_r;
  sq2_side_t         rs_side_r;

  assign c_sq = cs_c_r * cs_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_v_r <= 1'b0;
    end else if (adv) begin
      rs_v_r <= cs_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rs_rad_r  <= (2*Sq2W)'(32'h1000_0000 - $unsigned(c_sq));
      rs_side_r <= cs_side_r;
    end
  end

  logic            sq2_v;
  logic [Sq2W-1:0] sq2_root;
  sq2_side_t       sq2_side;

  hryc_sqrt #(
    .RootW (Sq2W),
    .SideW ($bits(sq2_side_t))
  ) u_sqrt_sine (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (rs_v_r),
    .in_rad    (rs_rad_r),
    .in_side   (rs_side_r),
    .out_valid (sq2_v),
    .out_root  (sq2_root),
    .out_side  (sq2_side)
  );

  // CORDIC start vector, turned by a quarter when it points left.
  logic signed [CordW-1:0] kx0, ky0;
  logic signed [CordW-1:0] k0_x_nxt, k0_y_nxt;
  logic signed [AngW-1:0]  k0_z_nxt;
  cord_side_t              k0_side_nxt;

  assign kx0 = CordW'(sq2_side.c) <<< 10;
  assign ky0 = CordW'($signed({1'b0, sq2_root})) <<< 10;

  always_comb begin
    if (kx0 < 0) begin
      k0_x_nxt = ky0;
      k0_y_nxt = -kx0;
      k0_z_nxt = AngW'(HalfPiQ16);
    end else begin
      k0_x_nxt = kx0;
      k0_y_nxt = ky0;
      k0_z_nxt = '0;
    end
  end

  assign k0_side_nxt.dz     = sq2_side.dz;
  assign k0_side_nxt.pos    = sq2_side.pos;
  assign k0_side_nxt.neg    = sq2_side.neg;
  assign k0_side_nxt.mz     = sq2_side.mz;
  assign k0_side_nxt.factor = sq2_side.factor;

  logic                    k0_v_r;
  logic signed [CordW-1:0] k0_x_r, k0_y_r;
  logic signed [AngW-1:0]  k0_z_r;
  cord_side_t              k0_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k0_v_r <= 1'b0;
    end else if (adv) begin
      k0_v_r <= sq2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k0_x_r    <= k0_x_nxt;
      k0_y_r    <= k0_y_nxt;
      k0_z_r    <= k0_z_nxt;
      k0_side_r <= k0_side_nxt;
    end
  end

  // CORDIC vectoring steps.
  logic                    cr_v_r    [CordicSteps];
  logic signed [CordW-1:0] cr_x_r    [CordicSteps];
  logic signed [CordW-1:0] cr_y_r    [CordicSteps];
  logic signed [AngW-1:0]  cr_z_r    [CordicSteps];
  cord_side_t              cr_side_r [CordicSteps];

  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    logic                    pv;
    logic signed [CordW-1:0] px, py, dx, dy;
    logic signed [AngW-1:0]  pz, da;
    cord_side_t              pside;

    if (i == 0) begin : g_first
      assign pv    = k0_v_r;
      assign px    = k0_x_r;
      assign py    = k0_y_r;
      assign pz    = k0_z_r;
      assign pside = k0_side_r;
    end else begin : g_next
      assign pv    = cr_v_r[i-1];
      assign px    = cr_x_r[i-1];
      assign py    = cr_y_r[i-1];
      assign pz    = cr_z_r[i-1];
      assign pside = cr_side_r[i-1];
    end

    assign dx = py >>> i;
    assign dy = px >>> i;
    assign da = AngW'(AtanQ16[i]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cr_v_r[i] <= 1'b0;
      end else if (adv) begin
        cr_v_r[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!py[CordW-1]) begin
          cr_x_r[i] <= px + dx;
          cr_y_r[i] <= py - dy;
          cr_z_r[i] <= pz + da;
        end else begin
          cr_x_r[i] <= px - dx;
          cr_y_r[i] <= py + dy;
          cr_z_r[i] <= pz - da;
        end
        cr_side_r[i] <= pside;
      end
    end
  end

  // Angle clamp, rounding to Q13 and sign.
  cord_side_t             ce_side;
  logic signed [AngW-1:0] ce_z, z_clamp, z_rnd;
  logic signed [15:0]     a_err_nxt;

  assign ce_side = cr_side_r[CordicSteps-1];
  assign ce_z    = cr_z_r[CordicSteps-1];

  always_comb begin
    if (ce_z < 0) begin
      z_clamp = '0;
    end else if (ce_z > AngW'(PiQ16)) begin
      z_clamp = AngW'(PiQ16);
    end else begin
      z_clamp = ce_z;
    end
    z_rnd = (z_clamp + AngW'(4)) >>> 3;
    if (z_rnd > AngW'(PiQ13)) begin
      z_rnd = AngW'(PiQ13);
    end
    if (ce_side.mz) begin
      a_err_nxt = '0;
    end else if (ce_side.pos) begin
      a_err_nxt = 16'(z_rnd);
    end else if (ce_side.neg) begin
      a_err_nxt = -16'(z_rnd);
    end else begin
      a_err_nxt = '0;
    end
  end

  logic               a_v_r;
  logic signed [15:0] a_err_r;
  logic signed [16:0] a_dz_r;
  logic [15:0]        a_factor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= cr_v_r[CordicSteps-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_err_r    <= a_err_nxt;
      a_dz_r     <= ce_side.dz;
      a_factor_r <= ce_side.factor;
    end
  end

  // E1: error plus trim, scaled factor, blend argument, negated rate error.
  logic signed [33:0] e_prod;
  logic [31:0]        fp_full;

  assign e_prod  = 34'(a_err_r) * 34'(K064Q16);
  assign fp_full = 32'(a_factor_r) * 32'd200;

  logic               e1_v_r;
  logic signed [16:0] e1_es_r;
  logic [23:0]        e1_fp_r;
  logic signed [32:0] e1_e_r;
  logic signed [17:0] e1_ndz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
    end else if (adv) begin
      e1_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_es_r  <= 17'(a_err_r) + 17'(trim_r);
      e1_fp_r  <= fp_full[23:0];
      e1_e_r   <= 33'(-e_prod - 34'(K02Q29));
      e1_ndz_r <= -18'(a_dz_r);
    end
  end

  // E2: P term base, squared blend argument, derivative gain scale.
  logic signed [65:0] e_sq;
  logic [31:0]        dk_full;

  assign e_sq    = 66'(e1_e_r) * 66'(e1_e_r);
  assign dk_full = 32'(deriv_gain_r) * 32'(K03Q16);

  logic               e2_v_r;
  logic signed [40:0] e2_pz_r;
  logic [21:0]        e2_wsq_r;
  logic [30:0]        e2_dk_r;
  logic signed [17:0] e2_ndz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_v_r <= 1'b0;
    end else if (adv) begin
      e2_v_r <= e1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e2_pz_r  <= 41'($signed({1'b0, e1_fp_r})) * 41'(e1_es_r);
      e2_wsq_r <= e_sq[63:42];
      e2_dk_r  <= dk_full[30:0];
      e2_ndz_r <= e1_ndz_r;
    end
  end

  // E3: blend weight, P gain, D term.
  logic signed [57:0] pp1;
  logic signed [49:0] dp;

  assign pp1 = 58'(e2_pz_r) * 58'($signed({1'b0, prop_gain_r}));
  assign dp  = 50'($signed({1'b0, e2_dk_r})) * 50'(e2_ndz_r);

  logic               e3_v_r;
  logic [16:0]        e3_w_r;
  logic signed [41:0] e3_pz_r;
  logic signed [44:0] e3_dt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e3_v_r <= 1'b0;
    end else if (adv) begin
      e3_v_r <= e2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e3_w_r  <= (e2_wsq_r >= 22'(WOne)) ? 17'(WOne) : e2_wsq_r[16:0];
      e3_pz_r <= 42'(pp1 >>> 16);
      e3_dt_r <= 45'(dp >>> 5);
    end
  end

  // E4: the 0.6 scale, the override term and 1 - w.
  logic signed [58:0] pp2;
  logic signed [40:0] cp;

  assign pp2 = 59'(e3_pz_r) * 59'(K06Q16);
  assign cp  = 41'($signed({1'b0, e3_w_r})) * 41'(override_r);

  logic               e4_v_r;
  logic signed [41:0] e4_pz_r;
  logic signed [40:0] e4_ct_r;
  logic [16:0]        e4_omw_r;
  logic signed [44:0] e4_dt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e4_v_r <= 1'b0;
    end else if (adv) begin
      e4_v_r <= e3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e4_pz_r  <= 42'(pp2 >>> 16);
      e4_ct_r  <= cp <<< 7;
      e4_omw_r <= 17'(WOne) - e3_w_r;
      e4_dt_r  <= e3_dt_r;
    end
  end

  // E5: weight of the P term.
  logic signed [59:0] pp3;

  assign pp3 = 60'(e4_pz_r) * 60'($signed({1'b0, e4_omw_r}));

  logic               e5_v_r;
  logic signed [41:0] e5_pz_r;
  logic signed [40:0] e5_ct_r;
  logic signed [44:0] e5_dt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e5_v_r <= 1'b0;
    end else if (adv) begin
      e5_v_r <= e4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e5_pz_r <= 42'(pp3 >>> 16);
      e5_ct_r <= e4_ct_r;
      e5_dt_r <= e4_dt_r;
    end
  end

  // Sum, rounding and saturation into the output register.
  logic signed [47:0] sum, sum_rnd;
  logic signed [24:0] cmd_wide;
  out_item_t          out_nxt;

  assign sum      = 48'(e5_pz_r) + 48'(e5_dt_r) + 48'(e5_ct_r);
  assign sum_rnd  = sum + 48'sd4194304;
  assign cmd_wide = 25'(sum_rnd >>> 23);

  always_comb begin
    if (cmd_wide > 25'sd32767) begin
      out_nxt.rudder_command  = 16'sh7fff;
      out_nxt.command_clipped = 1'b1;
    end else if (cmd_wide < -25'sd32768) begin
      out_nxt.rudder_command  = 16'sh8000;
      out_nxt.command_clipped = 1'b1;
    end else begin
      out_nxt.rudder_command  = 16'(cmd_wide);
      out_nxt.command_clipped = 1'b0;
    end
  end

  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= e5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r |-> (a_err_r <= 16'(PiQ13)) && (a_err_r >= -16'(PiQ13)))
    else $error("heading error outside of plus or minus pi");

  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.command_clipped) |->
      (out_item_r.rudder_command == 16'sh7fff) || (out_item_r.rudder_command == 16'sh8000))
    else $error("clipped command not at a rail");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

endmodule
